// File: hw/rtl/averaged_two_point_percent_map_macros.svh
// ----------------------------------------------------------------------------
// averaged two-point percent map: assertion macros
// shared assertion wrappers, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef AVERAGED_TWO_POINT_PERCENT_MAP_MACROS_SVH
`define AVERAGED_TWO_POINT_PERCENT_MAP_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define ATPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("atpm assertion failed");
// checked at every edge, reset included
`define ATPM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("atpm assertion failed");
`else
`define ATPM_ASSERT(lbl, prop)
`define ATPM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hw/rtl/atpm_pkg.sv
// ----------------------------------------------------------------------------
// atpm_pkg
// widths, constants and shared types of the averaged two-point percent map
// ----------------------------------------------------------------------------
package atpm_pkg;

    localparam int SAMPLES_PER_READING = 10;
    localparam int ADC_WIDTH           = 12;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 12;
    localparam int PCT_W    = 14;
    localparam int AVG_W    = 12;
    localparam int CFG_IDX_W = 2;

    // sample bits actually used
    localparam int USED_W = (ADC_WIDTH < SAMPLE_W) ? ADC_WIDTH : SAMPLE_W;
    localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
    localparam int SUM_W  = USED_W + CNT_W;

    // serial divider sizes
    localparam int PROD_W  = LEVEL_W + PCT_W;
    localparam int DVD_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DVS_W   = (LEVEL_W > CNT_W) ? LEVEL_W : CNT_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WET = CFG_IDX_W'(1);

    localparam logic [LEVEL_W-1:0] DRY_RESET = LEVEL_W'(4095);
    localparam logic [LEVEL_W-1:0] WET_RESET = LEVEL_W'(0);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: hw/rtl/atpm_accum.sv
// ----------------------------------------------------------------------------
// atpm_accum
// running sample sum and count for one reading
// ----------------------------------------------------------------------------
module atpm_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [atpm_pkg::SAMPLE_W-1:0] sample,
    output logic [atpm_pkg::SUM_W-1:0]    total,
    output logic                          last
);
    import atpm_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign total = sum_reg + SUM_W'(sample[USED_W-1:0]);
    assign last  = (count_reg == CNT_W'(SAMPLES_PER_READING - 1));

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (take)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = total;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/atpm_serdiv.sv
// ----------------------------------------------------------------------------
// atpm_serdiv
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "averaged_two_point_percent_map_macros.svh"

module atpm_serdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  atpm_pkg::div_req_t req,
    output atpm_pkg::div_rsp_t rsp
);
    import atpm_pkg::*;

    // dividend shifts out at the top while quotient bits enter at the bottom
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W+1:0] diff;
    logic             ge;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        ge        = !diff[DVS_W+1];
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    `ATPM_ASSERT(a_no_restart, busy_reg |-> !req.start)
    `ATPM_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg))
    `ATPM_ASSERT(a_rem_below_divisor, busy_reg && !$past(req.start) |-> rem_reg < dvs_reg)

endmodule

// File: hw/rtl/averaged_two_point_percent_map.sv
// ----------------------------------------------------------------------------
// averaged_two_point_percent_map
// averages a fixed number of converter samples and maps the average between
// a dry and a wet level to a clamped percentage in hundredths
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | adc_sample
//  out     | from block| out_valid/out_stall| percent_x100, average_level
//  cfg     | to block  | cfg_we             | cfg_index, cfg_data
//
//  the last sample starts two bit-serial divides (average, then percentage),
//  each giving DVD_W quotient bits; the percentage divide is skipped when the
//  average maps to zero or to full scale
//  in_stall is high from the last sample until the result is in the output
//  register; the output register holds one result while samples keep coming
//  reset clears the sum, count and valid flags and loads the default levels
// ----------------------------------------------------------------------------
`include "averaged_two_point_percent_map_macros.svh"

module averaged_two_point_percent_map (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [atpm_pkg::SAMPLE_W-1:0]  adc_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [atpm_pkg::PCT_W-1:0]     percent_x100,
    output logic [atpm_pkg::AVG_W-1:0]     average_level,
    input  logic                           cfg_we,
    input  logic [atpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atpm_pkg::LEVEL_W-1:0]   cfg_data
);
    import atpm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_AVG  = 5'b00010,
        S_MAP  = 5'b00100,
        S_PCT  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [LEVEL_W-1:0] dry_reg;
    logic [LEVEL_W-1:0] wet_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic [AVG_W-1:0]   out_avg_reg;
    logic               out_valid_reg;

    logic             accept;
    logic [SUM_W-1:0] total;
    logic             last;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic               map_zero;
    logic               map_full;
    logic [LEVEL_W-1:0] num;
    logic [LEVEL_W-1:0] span;
    logic [DVD_W-1:0]   product;
    logic               out_load;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    atpm_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (accept),
        .sample (adc_sample),
        .total  (total),
        .last   (last)
    );

    // two-point map setup, both orientations
    always_comb
    begin
        if (wet_reg < dry_reg)
        begin
            map_zero = (avg_reg >= dry_reg);
            num      = dry_reg - avg_reg;
            span     = dry_reg - wet_reg;
        end
        else
        begin
            map_zero = (wet_reg == dry_reg) || (avg_reg <= dry_reg);
            num      = avg_reg - dry_reg;
            span     = wet_reg - dry_reg;
        end
        // at or past wet the quotient is at least full scale
        map_full = (num >= span);
        product  = DVD_W'(num) * DVD_W'(PCT_FULL);
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(total);
        div_req.divisor  = DVS_W'(SAMPLES_PER_READING);
        if (state_reg == S_MAP)
        begin
            div_req.dividend = product;
            div_req.divisor  = DVS_W'(span);
            div_req.start    = !map_zero && !map_full;
        end
        else if (state_reg == S_IDLE)
        begin
            div_req.start = accept && last;
        end
    end

    atpm_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                if (map_zero || map_full)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_AVG && div_rsp.done)
        begin
            avg_reg <= div_rsp.quotient[AVG_W-1:0];
        end
        if (state_reg == S_MAP)
        begin
            pct_reg <= map_zero ? '0 : PCT_FULL;
        end
        else if (state_reg == S_PCT && div_rsp.done)
        begin
            pct_reg <= div_rsp.quotient[PCT_W-1:0];
        end
        if (out_load)
        begin
            out_pct_reg <= pct_reg;
            out_avg_reg <= avg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            dry_reg       <= DRY_RESET;
            wet_reg       <= WET_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DRY: dry_reg <= cfg_data;
                    REG_WET: wet_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign percent_x100  = out_pct_reg;
    assign average_level = out_avg_reg;

    `ATPM_ASSERT(a_pct_in_range, out_valid_reg |-> out_pct_reg <= PCT_FULL)
    `ATPM_ASSERT_ALWAYS(a_done_waits, div_rsp.done |-> (state_reg == S_AVG || state_reg == S_PCT))
    `ATPM_ASSERT(a_last_starts_div, state_reg == S_IDLE && accept && last |=> state_reg == S_AVG)

endmodule

// File: tb/percent_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percent_map_checker
// watches the sample, result and register ports of the percent map, keeps
// its own copy of the levels and the running sum, predicts each reading and
// compares every accepted result, field by field, against the oldest one
// ----------------------------------------------------------------------------
module percent_map_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [atpm_pkg::SAMPLE_W-1:0]  adc_sample,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [atpm_pkg::PCT_W-1:0]     percent_x100,
    input  logic [atpm_pkg::AVG_W-1:0]     average_level,
    input  logic                           cfg_we,
    input  logic [atpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atpm_pkg::LEVEL_W-1:0]   cfg_data,
    output int unsigned                    mismatches,
    output int unsigned                    outstanding
);
    import atpm_pkg::*;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [AVG_W-1:0] avg;
    } reading_t;

    reading_t           expected_readings[$];
    reading_t           oldest;
    logic [LEVEL_W-1:0] dry_copy;
    logic [LEVEL_W-1:0] wet_copy;
    logic [AVG_W-1:0]   avg_now;
    int unsigned        samples_in;
    int unsigned        sum_acc;

    assign outstanding = expected_readings.size();

    // linear map of an average between the two levels, either orientation
    function automatic logic [PCT_W-1:0] map_to_percent(
        input logic [LEVEL_W-1:0] avg,
        input logic [LEVEL_W-1:0] dry,
        input logic [LEVEL_W-1:0] wet
    );
        int unsigned num;
        int unsigned span;
        int unsigned q;
        if (wet < dry)
        begin
            if (avg >= dry)
                return '0;
            num  = dry - avg;
            span = dry - wet;
        end
        else
        begin
            // equal levels leave no span to divide by
            if (wet == dry || avg <= dry)
                return '0;
            num  = avg - dry;
            span = wet - dry;
        end
        q = (num * 10000) / span;
        if (q > PCT_FULL)
            q = PCT_FULL;
        return PCT_W'(q);
    endfunction

    task automatic flag(input string what, input int unsigned want, input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_copy   = DRY_RESET;
            wet_copy   = WET_RESET;
            samples_in = 0;
            sum_acc    = 0;
            mismatches = 0;
            expected_readings.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    flag("result with no reading pending, percent_x100", 0, percent_x100);
                else
                begin
                    oldest = expected_readings.pop_front();
                    if (percent_x100 !== oldest.pct)
                        flag("percent_x100", oldest.pct, percent_x100);
                    if (average_level !== oldest.avg)
                        flag("average_level", oldest.avg, average_level);
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == REG_DRY)
                    dry_copy = cfg_data;
                else if (cfg_index == REG_WET)
                    wet_copy = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                sum_acc += adc_sample[USED_W-1:0];
                samples_in++;
                if (samples_in == SAMPLES_PER_READING)
                begin
                    avg_now = AVG_W'(sum_acc / SAMPLES_PER_READING);
                    expected_readings.push_back(
                        '{pct: map_to_percent(avg_now, dry_copy, wet_copy), avg: avg_now});
                    samples_in = 0;
                    sum_acc    = 0;
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives readings of ten samples into the percent map under a series of
// dry/wet level settings, with random gaps and output stalls; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    import atpm_pkg::*;

    localparam int PHASES             = 10;
    localparam int READINGS_PER_PHASE = 6;
    localparam int DRAIN_CYCLES       = 80;
    localparam int MAX_LEVEL          = 4095;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  adc_sample;
    logic                 out_valid;
    logic                 out_stall;
    logic [PCT_W-1:0]     percent_x100;
    logic [AVG_W-1:0]     average_level;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;
    int unsigned          mismatches;
    int unsigned          outstanding;
    bit                   quiet;

    always #6 clk = ~clk;

    averaged_two_point_percent_map u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .percent_x100 (percent_x100),
        .average_level(average_level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    percent_map_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .percent_x100 (percent_x100),
        .average_level(average_level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    function automatic int clamp_level(input int v);
        if (v < 0)
            return 0;
        if (v > MAX_LEVEL)
            return MAX_LEVEL;
        return v;
    endfunction

    // valid stays high after acceptance; the next call or a gap decides
    task automatic send_sample(input int v);
        in_valid   <= 1'b1;
        adc_sample <= SAMPLE_W'(v);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_reading(input int dry, input int wet);
        int  target;
        int  spread;
        int  s;
        bit  calm;
        calm = quiet || ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0:       target = dry;
            1:       target = wet;
            2:       target = dry + int'($urandom_range(0, 4)) - 2;
            3:       target = wet + int'($urandom_range(0, 4)) - 2;
            4, 5:    target = $urandom_range(dry, wet);
            6:       target = $urandom_range(0, MAX_LEVEL);
            default: target = -1;
        endcase
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 3;
            2:       spread = 60;
            default: spread = 2047;
        endcase
        for (int i = 0; i < SAMPLES_PER_READING; i++)
        begin
            // negative target means samples only at the rails
            if (target < 0)
                s = $urandom_range(0, 1) ? MAX_LEVEL : 0;
            else
                s = clamp_level(target + int'($urandom_range(0, 2 * spread)) - spread);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            send_sample(s);
        end
    endtask

    task automatic load_levels(input int dry, input int wet);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DRY;
        cfg_data  <= LEVEL_W'(dry);
        @(posedge clk);
        cfg_index <= REG_WET;
        cfg_data  <= LEVEL_W'(wet);
        @(posedge clk);
        // writes to the unused indexes must leave both levels alone
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        cfg_data  <= LEVEL_W'($urandom_range(0, MAX_LEVEL));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int dry;
        int wet;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        adc_sample = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_DRY;
        cfg_data   = '0;
        quiet      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels: all-zero reading sits on wet, all-max sits on dry
        dry = DRY_RESET;
        wet = WET_RESET;
        repeat (SAMPLES_PER_READING) send_sample(0);
        repeat (SAMPLES_PER_READING) send_sample(MAX_LEVEL);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES - 1)
                quiet = 1'b1;
            if (phase != 0)
            begin
                case (phase)
                    1:       begin dry = 0;    wet = MAX_LEVEL; end
                    2:       begin dry = MAX_LEVEL; wet = 0;    end
                    3:       begin dry = 2048; wet = 2048;      end
                    4:       begin dry = 0;    wet = 0;         end
                    5:       begin dry = MAX_LEVEL; wet = MAX_LEVEL; end
                    6:       begin dry = 1000; wet = 3000;      end
                    7:       begin dry = 3100; wet = 900;       end
                    8:       begin dry = 2000; wet = 2001;      end
                    default:
                    begin
                        dry = $urandom_range(0, MAX_LEVEL);
                        wet = $urandom_range(0, MAX_LEVEL);
                    end
                endcase
                load_levels(dry, wet);
            end
            repeat (READINGS_PER_PHASE) send_reading(dry, wet);
            in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("averaged_two_point_percent_map verification clean");
        else
            $display("averaged_two_point_percent_map verification failed");
        $finish;
    end

    // result side: random stall bursts, none once the run turns quiet
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 14)) @(posedge clk);
                if (!quiet)
                    out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("averaged_two_point_percent_map verification failed");
        $finish;
    end

endmodule
